// ===== rtl/core/scb_pkg.sv =====
`timescale 1ns / 1ps
package scb_pkg;

    localparam int SCENES_DEF       = 8;
    localparam int DEFAULT_BARS_DEF = 4;
    localparam int LAYERS_DEF       = 4;

    localparam logic [3:0] FULL_MASK = 4'hF;

    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 24;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic REG_LOOP_SONG = 1'b0;

    typedef enum logic [2:0] {
        MODE_TICK   = 3'd0,
        MODE_ENABLE = 3'd1,
        MODE_WRITE  = 3'd2,
        MODE_COUNT  = 3'd3,
        MODE_APPEND = 3'd4,
        MODE_DELETE = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK1,
        ST_TICK2,
        ST_DEL_CHK,
        ST_DEL_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] bar_count;
        logic        playing;
        logic        enable_value;
        logic [2:0]  scene_index;
        logic [7:0]  scene_length;
        logic [3:0]  scene_mask;
        logic [3:0]  new_count;
    } t_item;

    typedef struct packed {
        logic [7:0] bars;
        logic [3:0] mask;
    } t_entry;

    typedef struct packed {
        logic       appended;
        logic [7:0] bars_in_scene;
        logic       song_on;
        logic [3:0] scene_total;
        logic [2:0] current_scene;
        logic [3:0] audible_mask;
        logic       mask_apply;
    } t_status;

endpackage

// ===== rtl/core/scb_mem.sv =====
`timescale 1ns / 1ps
module scb_mem import scb_pkg::*; #(
    parameter int SCENES       = SCENES_DEF,
    parameter int DEFAULT_BARS = DEFAULT_BARS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_wr_en,
    input  logic [(SCENES > 1 ? $clog2(SCENES) : 1)-1:0] i_wr_addr,
    input  t_entry                                i_wr_entry,
    input  logic                                  i_rd_en,
    input  logic [(SCENES > 1 ? $clog2(SCENES) : 1)-1:0] i_rd_addr,
    output t_entry                                o_rd_entry
);

    localparam t_entry DEF_ENTRY = '{bars: 8'(DEFAULT_BARS), mask: FULL_MASK};

    t_entry              r_mem [SCENES];
    logic [SCENES-1:0]   r_valid;
    t_entry              r_rd_data;
    logic                r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_entry = r_rd_hit ? r_rd_data : DEF_ENTRY;

endmodule

// ===== rtl/core/scb_ctrl.sv =====
`timescale 1ns / 1ps
module scb_ctrl import scb_pkg::*; #(
    parameter int SCENES       = SCENES_DEF,
    parameter int DEFAULT_BARS = DEFAULT_BARS_DEF,
    parameter int LAYERS       = LAYERS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_loop_song,
    input  logic                                  i_item_valid,
    input  t_item                                 i_item,
    output logic                                  o_item_ready,
    input  logic                                  i_out_free,
    output logic                                  o_result_valid,
    output t_status                               o_status,
    output logic                                  o_wr_en,
    output logic [(SCENES > 1 ? $clog2(SCENES) : 1)-1:0] o_wr_addr,
    output t_entry                                o_wr_entry,
    output logic                                  o_rd_en,
    output logic [(SCENES > 1 ? $clog2(SCENES) : 1)-1:0] o_rd_addr,
    input  t_entry                                i_rd_entry
);

    localparam int IDX_W = (SCENES > 1) ? $clog2(SCENES) : 1;
    localparam int CNT_W = $clog2(SCENES + 1);
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
    localparam logic [CMP_W-1:0] SCENES_X = CMP_W'(SCENES);
    localparam logic [CMP_W-1:0] ONE_X    = CMP_W'(1);
    localparam logic [3:0] LAYER_BITS = 4'((1 << LAYERS) - 1) & FULL_MASK;
    localparam t_entry DEF_ENTRY = '{bars: 8'(DEFAULT_BARS), mask: FULL_MASK};

    t_state             r_state, n_state;
    t_item              r_item, n_item;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_cur, n_cur;
    logic [31:0]        r_anchor, n_anchor;
    logic               r_en, n_en;
    logic               r_pending, n_pending;
    logic [3:0]         r_shown, n_shown;
    logic               r_applied, n_applied;
    logic               r_added, n_added;
    logic [IDX_W-1:0]   r_i, n_i;

    logic [32:0]        w_diff;
    logic               w_behind;
    logic [31:0]        w_bar_next;
    logic               w_short;
    logic               w_run;
    logic [CMP_W-1:0]   w_cur_x, w_cnt_x, w_idx_x, w_cur_inc, w_i_inc, w_cnt_dec, w_clamp;
    logic               w_wrap, w_idx_ok, w_i_more;
    logic [IDX_W-1:0]   w_nxt_idx;
    logic [7:0]         w_bis;

    assign w_diff     = {1'b0, r_item.bar_count} - {1'b0, r_anchor};
    assign w_behind   = w_diff[32];
    assign w_bar_next = r_item.bar_count + 32'd1;
    assign w_short    = w_diff[31:0] < {24'd0, i_rd_entry.bars};
    assign w_run      = r_en & r_item.playing;
    assign w_cur_x    = CMP_W'(r_cur);
    assign w_cnt_x    = CMP_W'(r_count);
    assign w_idx_x    = CMP_W'(r_item.scene_index);
    assign w_cur_inc  = w_cur_x + ONE_X;
    assign w_wrap     = w_cur_inc >= w_cnt_x;
    assign w_nxt_idx  = w_wrap ? '0 : IDX_W'(w_cur_inc);
    assign w_idx_ok   = w_idx_x < w_cnt_x;
    assign w_i_inc    = CMP_W'(r_i) + ONE_X;
    assign w_i_more   = w_i_inc < w_cnt_x;
    assign w_cnt_dec  = w_cnt_x - ONE_X;
    assign w_bis      = (w_run && !w_behind) ? w_diff[7:0] : 8'd0;

    always_comb begin
        if (CMP_W'(r_item.new_count) > SCENES_X) begin
            w_clamp = SCENES_X;
        end else if (r_item.new_count == 4'd0) begin
            w_clamp = ONE_X;
        end else begin
            w_clamp = CMP_W'(r_item.new_count);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (r_item.mode)
                    MODE_TICK:   n_state = ST_TICK1;
                    MODE_DELETE: begin
                        n_state = (w_idx_ok && w_cnt_x > ONE_X) ? ST_DEL_CHK : ST_DONE;
                    end
                    default:     n_state = ST_DONE;
                endcase
            end
            ST_TICK1: begin
                if (!w_run) begin
                    n_state = ST_DONE;
                end else if (w_behind) begin
                    n_state = ST_TICK2;
                end else if (w_short || (w_wrap && !i_loop_song)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_TICK2;
                end
            end
            ST_TICK2:   n_state = ST_DONE;
            ST_DEL_CHK: n_state = w_i_more ? ST_DEL_WR : ST_DONE;
            ST_DEL_WR:  n_state = ST_DEL_CHK;
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_item     = r_item;
        n_count    = r_count;
        n_cur      = r_cur;
        n_anchor   = r_anchor;
        n_en       = r_en;
        n_pending  = r_pending;
        n_shown    = r_shown;
        n_applied  = r_applied;
        n_added    = r_added;
        n_i        = r_i;
        o_wr_en    = 1'b0;
        o_wr_addr  = '0;
        o_wr_entry = DEF_ENTRY;
        o_rd_en    = 1'b0;
        o_rd_addr  = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    n_item    = i_item;
                    n_applied = 1'b0;
                    n_added   = 1'b0;
                end
            end
            ST_EXEC: begin
                case (r_item.mode)
                    MODE_TICK: begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = r_cur;
                    end
                    MODE_ENABLE: begin
                        if (r_en != r_item.enable_value) begin
                            n_en      = r_item.enable_value;
                            n_pending = 1'b1;
                            if (r_item.enable_value) begin
                                n_cur    = '0;
                                n_anchor = w_bar_next;
                            end
                        end
                    end
                    MODE_WRITE: begin
                        if (w_idx_ok) begin
                            o_wr_en         = 1'b1;
                            o_wr_addr       = IDX_W'(w_idx_x);
                            o_wr_entry.bars = (r_item.scene_length == 8'd0) ?
                                              8'(DEFAULT_BARS) : r_item.scene_length;
                            o_wr_entry.mask = r_item.scene_mask & FULL_MASK;
                            if (r_en && w_idx_x == w_cur_x) begin
                                n_pending = 1'b1;
                            end
                        end
                    end
                    MODE_COUNT: begin
                        n_count = CNT_W'(w_clamp);
                        if (w_cur_x >= w_clamp) begin
                            n_cur    = '0;
                            n_anchor = w_bar_next;
                            if (r_en) begin
                                n_pending = 1'b1;
                            end
                        end
                    end
                    MODE_APPEND: begin
                        if (w_cnt_x < SCENES_X) begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = IDX_W'(w_cnt_x);
                            n_count   = CNT_W'(w_cnt_x + ONE_X);
                            n_added   = 1'b1;
                        end
                    end
                    MODE_DELETE: begin
                        n_i = IDX_W'(w_idx_x);
                    end
                    default: ;
                endcase
            end
            ST_TICK1: begin
                if (r_pending) begin
                    n_pending = 1'b0;
                    n_shown   = r_en ? (i_rd_entry.mask & LAYER_BITS) : LAYER_BITS;
                    n_applied = 1'b1;
                end
                if (w_run) begin
                    if (w_behind) begin
                        n_cur     = '0;
                        n_anchor  = r_item.bar_count;
                        o_rd_en   = 1'b1;
                        o_rd_addr = '0;
                    end else if (!w_short && !(w_wrap && !i_loop_song)) begin
                        n_cur     = w_nxt_idx;
                        n_anchor  = r_anchor + {24'd0, i_rd_entry.bars};
                        o_rd_en   = 1'b1;
                        o_rd_addr = w_nxt_idx;
                    end
                end
            end
            ST_TICK2: begin
                if (!w_short) begin
                    n_anchor = r_item.bar_count;
                end
                n_shown   = i_rd_entry.mask & LAYER_BITS;
                n_applied = 1'b1;
            end
            ST_DEL_CHK: begin
                if (w_i_more) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = IDX_W'(w_i_inc);
                end else begin
                    n_count = CNT_W'(w_cnt_dec);
                    if (w_cur_x >= w_idx_x) begin
                        if (w_cur_x >= w_cnt_dec) begin
                            n_cur = '0;
                        end else if (w_cur_x > w_idx_x) begin
                            n_cur = r_cur - IDX_W'(1);
                        end
                        n_anchor = w_bar_next;
                        if (r_en) begin
                            n_pending = 1'b1;
                        end
                    end
                end
            end
            ST_DEL_WR: begin
                o_wr_en    = 1'b1;
                o_wr_addr  = r_i;
                o_wr_entry = i_rd_entry;
                n_i        = IDX_W'(w_i_inc);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= CNT_W'(1);
            r_cur     <= '0;
            r_anchor  <= '0;
            r_en      <= 1'b0;
            r_pending <= 1'b0;
            r_shown   <= LAYER_BITS;
            r_applied <= 1'b0;
            r_added   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cur     <= n_cur;
            r_anchor  <= n_anchor;
            r_en      <= n_en;
            r_pending <= n_pending;
            r_shown   <= n_shown;
            r_applied <= n_applied;
            r_added   <= n_added;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_i    <= n_i;
    end

    assign o_item_ready   = (r_state == ST_IDLE);
    assign o_result_valid = (r_state == ST_DONE) && i_out_free;

    assign o_status.mask_apply    = r_applied;
    assign o_status.audible_mask  = r_shown;
    assign o_status.current_scene = 3'(r_cur);
    assign o_status.scene_total   = 4'(r_count);
    assign o_status.song_on       = r_en;
    assign o_status.bars_in_scene = w_bis;
    assign o_status.appended      = r_added;

endmodule

// ===== rtl/core/scene_chain_bar_sequencer.sv =====
`timescale 1ns / 1ps
// Scene chain sequencer for a song mode. Each input beat on the s_axis channel carries
// one command: tuser holds the mode (tick, enable, write scene, set count, append,
// delete) and tdata holds its operands. Every command returns exactly one status beat
// on the m_axis channel with the applied layer mask, the active scene, the scene count,
// the song state, the bars elapsed in the scene and the append flag.
// The scene table lives in a synchronous memory with one read port and one write port,
// and the block works on one command at a time. A tick passes through an execute step
// and a first tick step, and through a second tick step when it rewinds or moves to
// another scene; enable, write, set count, append and an ignored delete go from the
// execute step to the done step; a delete adds a check step and a write step for every
// scene that moves down, then a last check step. The next beat is accepted in idle.
// A finished result sits in an output register; the next command is accepted while it
// waits, and the block only holds in its final step when a second result is ready and
// the receiver still stalls the first.
// Reset clears the chain to one scene of default length with all layers audible, turns
// song mode off and sets loop_song. No clearing pass is needed after reset.
// The APB port holds loop_song at address 0; write it only while the block is idle.
module scene_chain_bar_sequencer import scb_pkg::*; #(
    parameter int SCENES       = SCENES_DEF,
    parameter int DEFAULT_BARS = DEFAULT_BARS_DEF,
    parameter int LAYERS       = LAYERS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // bar_count[31:0], playing[32], enable_value[33], scene_index[36:34],
    // scene_length[44:37], scene_mask[48:45], new_count[52:49], zero[55:53]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // mode[2:0]
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // mask_apply[0], audible_mask[4:1], current_scene[7:5], scene_total[11:8],
    // song_on[12], bars_in_scene[20:13], appended[21], zero[23:22]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    localparam int IDX_W = (SCENES > 1) ? $clog2(SCENES) : 1;

    t_item            w_item;
    t_status          w_status;
    logic             w_result_valid;
    logic             w_out_free;
    logic             w_wr_en, w_rd_en;
    logic [IDX_W-1:0] w_wr_addr, w_rd_addr;
    t_entry           w_wr_entry, w_rd_entry;
    logic             w_cfg_wr;

    logic             r_loop_song;
    logic             r_out_valid;
    t_status          r_out_status;

    assign w_item.mode         = t_mode'(s_axis_tuser[2:0]);
    assign w_item.bar_count    = s_axis_tdata[31:0];
    assign w_item.playing      = s_axis_tdata[32];
    assign w_item.enable_value = s_axis_tdata[33];
    assign w_item.scene_index  = s_axis_tdata[36:34];
    assign w_item.scene_length = s_axis_tdata[44:37];
    assign w_item.scene_mask   = s_axis_tdata[48:45];
    assign w_item.new_count    = s_axis_tdata[52:49];

    assign w_out_free = !r_out_valid || m_axis_tready;

    scb_ctrl #(
        .SCENES       (SCENES),
        .DEFAULT_BARS (DEFAULT_BARS),
        .LAYERS       (LAYERS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_loop_song    (r_loop_song),
        .i_item_valid   (s_axis_tvalid),
        .i_item         (w_item),
        .o_item_ready   (s_axis_tready),
        .i_out_free     (w_out_free),
        .o_result_valid (w_result_valid),
        .o_status       (w_status),
        .o_wr_en        (w_wr_en),
        .o_wr_addr      (w_wr_addr),
        .o_wr_entry     (w_wr_entry),
        .o_rd_en        (w_rd_en),
        .o_rd_addr      (w_rd_addr),
        .i_rd_entry     (w_rd_entry)
    );

    scb_mem #(
        .SCENES       (SCENES),
        .DEFAULT_BARS (DEFAULT_BARS)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (w_wr_addr),
        .i_wr_entry (w_wr_entry),
        .i_rd_en    (w_rd_en),
        .i_rd_addr  (w_rd_addr),
        .o_rd_entry (w_rd_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_result_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result_valid) begin
            r_out_status <= w_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_status);

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_LOOP_SONG);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_song <= 1'b1;
        end else if (w_cfg_wr) begin
            r_loop_song <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_LOOP_SONG) ? {{(PDATA_W-1){1'b0}}, r_loop_song} : '0;

endmodule

// ===== rtl/core/scb_checker.sv =====
`timescale 1ns / 1ps
module scb_checker import scb_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat shown right after reset");

    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[11:8] != 4'd0)
        else $error("scene count reported as zero");

    a_off_no_bars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[12] |-> m_axis_tdata[20:13] == 8'd0)
        else $error("bars counted while song mode is off");

    a_append_no_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[21] |-> !m_axis_tdata[0])
        else $error("append reported a mask apply");

endmodule

bind scene_chain_bar_sequencer scb_checker u_scb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
